// ===== rtl/amc_pkg.sv =====
// Shared types, constants and helpers for the single-axis box motion clip.
// No dependencies; imported by every module of the block.
package amc_pkg;

  // Coordinate format: signed Q16.16 two's complement
  localparam int COORD_WIDTH = 32;
  // Differences and gap-minus-motion terms need two guard bits
  localparam int WIDE_W      = COORD_WIDTH + 2;

  // Stream packing
  localparam int IN_COORDS   = 7;
  localparam int IN_TDATA_W  = ((IN_COORDS * COORD_WIDTH + 7) / 8) * 8;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = ((COORD_WIDTH + 7) / 8) * 8;
  localparam int CFG_INDEX_W = 3;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [WIDE_W-1:0]      wide_t;
  typedef logic [1:0]                    axis_t;
  typedef logic [2:0][COORD_WIDTH-1:0]   coord3_t;

  localparam axis_t AXIS_X = 2'd0;
  localparam axis_t AXIS_Y = 2'd1;
  localparam axis_t AXIS_Z = 2'd2;

  // Saturation bounds, in the wide format
  localparam wide_t SAT_HI = {{(WIDE_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
  localparam wide_t SAT_LO = ~SAT_HI;

  // Box: lower and upper bounds, index 0 x, 1 y, 2 z
  typedef struct packed {
    coord3_t lo;
    coord3_t hi;
  } box_t;

  // One clip request as held in the input stage
  typedef struct packed {
    box_t   obstacle;
    coord_t motion;
    axis_t  axis;
    logic   pushout_disabled;
  } clip_req_t;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } cfg_reg_t;

  // Next axis round the cycle x -> y -> z -> x
  function automatic axis_t axis_after(input axis_t a);
    case (a)
      AXIS_X:  axis_after = AXIS_Y;
      AXIS_Y:  axis_after = AXIS_Z;
      AXIS_Z:  axis_after = AXIS_X;
      default: axis_after = AXIS_X;
    endcase
  endfunction

  // Axis two steps round the cycle
  function automatic axis_t axis_after2(input axis_t a);
    case (a)
      AXIS_X:  axis_after2 = AXIS_Z;
      AXIS_Y:  axis_after2 = AXIS_X;
      AXIS_Z:  axis_after2 = AXIS_Y;
      default: axis_after2 = AXIS_X;
    endcase
  endfunction

  // Select one coordinate of a bound triple
  function automatic coord_t pick(input coord3_t v, input axis_t a);
    case (a)
      AXIS_X:  pick = $signed(v[0]);
      AXIS_Y:  pick = $signed(v[1]);
      AXIS_Z:  pick = $signed(v[2]);
      default: pick = $signed(v[0]);
    endcase
  endfunction

endpackage

// ===== rtl/amc_cfg.sv =====
// Configuration register file holding the moving box bounds.
// Depends on amc_pkg.
module amc_cfg
  import amc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data,
  output box_t                   mover
);

  box_t mover_r;
  box_t mover_nxt;

  // Register write decode; indexes past the list are dropped
  always_comb begin
    mover_nxt = mover_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_MIN_X: mover_nxt.lo[0] = cfg_data;
        REG_MIN_Y: mover_nxt.lo[1] = cfg_data;
        REG_MIN_Z: mover_nxt.lo[2] = cfg_data;
        REG_MAX_X: mover_nxt.hi[0] = cfg_data;
        REG_MAX_Y: mover_nxt.hi[1] = cfg_data;
        REG_MAX_Z: mover_nxt.hi[2] = cfg_data;
        default:   mover_nxt = mover_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mover_r <= '0;
    end else begin
      mover_r <= mover_nxt;
    end
  end

  assign mover = mover_r;

endmodule

// ===== rtl/amc_clip.sv =====
// Combinational single-axis clip of the moving box against one obstacle.
// Depends on amc_pkg.
module amc_clip
  import amc_pkg::*;
(
  input  box_t      mover,
  input  clip_req_t req,
  output coord_t    clipped_motion
);

  axis_t a1;
  axis_t a2;
  logic  hit_a1;
  logic  hit_a2;
  wide_t m;
  wide_t gap_lo;
  wide_t gap_hi;
  wide_t res;
  wide_t res_sat;

  // Strict overlap on the two cross axes
  always_comb begin
    a1 = axis_after(req.axis);
    a2 = axis_after2(req.axis);
    hit_a1 = (pick(req.obstacle.hi, a1) > pick(mover.lo, a1)) &&
             (pick(req.obstacle.lo, a1) < pick(mover.hi, a1));
    hit_a2 = (pick(req.obstacle.hi, a2) > pick(mover.lo, a2)) &&
             (pick(req.obstacle.lo, a2) < pick(mover.hi, a2));
  end

  // Gaps along the clip axis, formed wide
  always_comb begin
    m      = WIDE_W'(req.motion);
    gap_lo = WIDE_W'(pick(req.obstacle.hi, req.axis)) - WIDE_W'(pick(mover.lo, req.axis));
    gap_hi = WIDE_W'(pick(req.obstacle.lo, req.axis)) - WIDE_W'(pick(mover.hi, req.axis));
  end

  // Clip decision; compares against a signed zero
  always_comb begin
    if (m == '0) begin
      res = '0;
    end else if (!(req.axis inside {AXIS_X, AXIS_Y, AXIS_Z})) begin
      res = m;
    end else if (!hit_a1 || !hit_a2) begin
      res = m;
    end else if (gap_lo <= wide_t'(0)) begin
      // obstacle below: clamp downward motion
      res = ((gap_lo - m) > wide_t'(0)) ? gap_lo : m;
    end else if (gap_hi >= wide_t'(0)) begin
      // obstacle above: clamp upward motion
      res = ((gap_hi - m) < wide_t'(0)) ? gap_hi : m;
    end else if (req.pushout_disabled) begin
      res = m;
    end else begin
      // already overlapping: shorter push-out, ties go downward
      res = (gap_lo < -gap_hi) ? gap_lo : gap_hi;
    end
  end

  // Saturate to the coordinate range
  always_comb begin
    if (res > SAT_HI) begin
      res_sat = SAT_HI;
    end else if (res < SAT_LO) begin
      res_sat = SAT_LO;
    end else begin
      res_sat = res;
    end
  end

  assign clipped_motion = res_sat[COORD_WIDTH-1:0];

endmodule

// ===== rtl/aabb_axis_motion_clip.sv =====
// An accepted input is held in the input register, then its result in the output register, unless stalled.
// Throughput: one item per cycle while the output is not stalled; an input register and an output register
// are separated by one pass of compare/subtract logic in amc_clip.
// While a result waits, the input stage accepts only if it is empty.
// Reset (rst_n low, synchronous) empties both stages and clears the moving box to 0.
// Top level: stream ports, input/output stages; uses amc_pkg, amc_cfg, amc_clip.
module aabb_axis_motion_clip
  import amc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  // obstacle_min_x, _min_y, _min_z, obstacle_max_x, _max_y, _max_z, motion
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // axis [1:0], pushout_disabled [2]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // clipped_motion
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  box_t      mover;
  clip_req_t req_in;
  clip_req_t s1_req_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  coord_t    clipped;
  coord_t    out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      advance;

  assign cfg_ready = 1'b1;

  amc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .mover     (mover)
  );

  // Unpack the input transaction
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      req_in.obstacle.lo[i] = in_tdata[i*COORD_WIDTH +: COORD_WIDTH];
      req_in.obstacle.hi[i] = in_tdata[(i+3)*COORD_WIDTH +: COORD_WIDTH];
    end
    req_in.motion           = $signed(in_tdata[6*COORD_WIDTH +: COORD_WIDTH]);
    req_in.axis             = in_tuser[1:0];
    req_in.pushout_disabled = in_tuser[2];
  end

  // Stage handshake
  assign advance       = !out_valid_r || out_tready;
  assign in_tready     = !s1_valid_r || advance;
  assign s1_valid_nxt  = in_tready ? in_tvalid : s1_valid_r;
  assign out_valid_nxt = advance ? s1_valid_r : out_valid_r;

  amc_clip u_clip (
    .mover          (mover),
    .req            (s1_req_r),
    .clipped_motion (clipped)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r <= req_in;
    end
    if (advance && s1_valid_r) begin
      out_data_r <= clipped;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'($unsigned(out_data_r));

endmodule

// ===== rtl/amc_checker.sv =====
// Port-level checker for aabb_axis_motion_clip, attached by bind.
// Depends on amc_pkg.
module amc_checker
  import amc_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic                   cfg_valid,
  input logic                   cfg_ready
);

  logic in_acc;
  logic zero_motion;

  assign in_acc      = in_tvalid && in_tready;
  assign zero_motion = in_tdata[6*COORD_WIDTH +: COORD_WIDTH] == '0;

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A waiting result is held
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped or changed while stalled");

  // An accepted item reaches the output if the sink is ready while it sits in the input stage
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc ##1 out_tready |=> out_tvalid)
    else $error("result missing after accepted transaction");

  // Zero motion always yields zero
  a_zero_motion: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && zero_motion ##1 out_tready |=> out_tdata == '0)
    else $error("zero motion gave non-zero result");

  // Configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind aabb_axis_motion_clip amc_checker u_amc_checker (.*);
